/* src/ksom_pkg.sv */
// ----------------------------------------------------------------------------
// ksom_pkg
// shared types, codes and widths of the self-organizing map training unit
// ----------------------------------------------------------------------------
package ksom_pkg;

	localparam int GRID_SIDE_DEF = 8;

	localparam int RC_W       = 3;
	localparam int W_W        = 16;
	localparam int LRATE_W    = 16;
	localparam int RAD_W      = 13;
	localparam int IDX_W      = 2;
	localparam int CMD_W      = 2;
	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 40;

	// sized for the largest grid side of 32
	localparam int DSQ_W   = 11;
	localparam int SQV_W   = 44;
	localparam int SQ_TOP  = 42;
	localparam int ROOT_W  = 22;
	localparam int DIV_W   = 32;
	localparam int DCNT_W  = 5;
	localparam int T_W     = 16;
	localparam int TERM_W  = 33;
	localparam int PROD_W  = TERM_W + T_W;
	localparam int INFL_W  = 17;
	localparam int GAIN_W  = 34;
	localparam int MAG_W   = 17;
	localparam int MOV_W   = MAG_W + GAIN_W;
	localparam int K_W     = 4;

	localparam logic [T_W-1:0] T_MAX    = 16'd32768;
	localparam logic [K_W-1:0] K_LAST   = 4'd10;

	localparam logic [CMD_W-1:0] CMD_TRAIN = 2'd0;
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd2;

	localparam logic [IDX_W-1:0] REG_LEARNING_RATE        = 2'd0;
	localparam logic [IDX_W-1:0] REG_NEIGHBOURHOOD_RADIUS = 2'd1;

	localparam logic [LRATE_W-1:0] LRATE_RESET = 16'hFFFF;
	localparam logic [RAD_W-1:0]   RAD_RESET   = 13'd1024;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_READ_WAIT,
		ST_SRCH,
		ST_SRCH_WAIT,
		ST_UPD_RD,
		ST_UPD_CHK,
		ST_SQRT,
		ST_DIV_T,
		ST_T_LATCH,
		ST_EXP_MUL,
		ST_EXP_DSTART,
		ST_EXP_DIV,
		ST_EXP_ACC,
		ST_GAIN,
		ST_MOVE,
		ST_WB,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic cap_in;
		logic load_wr;
		logic read_issue;
		logic srch_start;
		logic srch_issue;
		logic upd_start;
		logic upd_read;
		logic upd_chk;
		logic upd_next;
		logic sqrt_start;
		logic div_t_start;
		logic t_latch;
		logic exp_mul;
		logic exp_div_start;
		logic exp_acc;
		logic gain_calc;
		logic move_mul;
		logic wb;
		logic out_load;
	} ksom_cmd_t;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic             cnt_last;
		logic             srch_busy;
		logic             in_nbhd;
		logic             t_zero;
		logic             sqrt_busy;
		logic             div_busy;
		logic             exp_done;
		logic             out_free;
	} ksom_stat_t;

endpackage

/* src/ksom_ram.sv */
// ----------------------------------------------------------------------------
// ksom_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module ksom_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

/* src/ksom_dp.sv */
// ----------------------------------------------------------------------------
// ksom_dp
// datapath: weight store, winner search pipeline, square root, divider,
// exponential series, weight update and output register
// ----------------------------------------------------------------------------
module ksom_dp #(
	parameter int GRID_SIDE = ksom_pkg::GRID_SIDE_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  ksom_pkg::ksom_cmd_t                cmd,
	output ksom_pkg::ksom_stat_t               stat,
	input  logic [ksom_pkg::CMD_W-1:0]         s_tuser,
	input  logic [ksom_pkg::IN_DATA_W-1:0]     s_tdata,
	input  logic                               cfg_valid,
	input  logic [ksom_pkg::IDX_W-1:0]         cfg_index,
	input  logic [ksom_pkg::LRATE_W-1:0]       cfg_data,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [ksom_pkg::OUT_DATA_W-1:0]    m_tdata
);
	import ksom_pkg::*;

	localparam int CW    = $clog2(GRID_SIDE);
	localparam int DEPTH = GRID_SIDE * GRID_SIDE;
	localparam int AW    = $clog2(DEPTH);
	localparam int RR_W  = 2 * RAD_W;
	localparam int NB_W  = DSQ_W + 16;
	localparam logic [CW-1:0] LAST_RC = CW'(GRID_SIDE - 1);

	// returns {saturated, new weight}
	function automatic logic [W_W:0] step_w(input logic [W_W-1:0] w, input logic neg,
			input logic [MOV_W-1:0] p);
		logic [MOV_W:0]         rnd;
		logic signed [W_W+4:0]  nw;
		logic [W_W:0]           r;
		rnd = {1'b0, p} + ((MOV_W + 1)'(1) << 31);
		if (neg) begin
			nw = $signed({{5{w[W_W-1]}}, w}) - $signed({1'b0, rnd[MOV_W:32]});
		end else begin
			nw = $signed({{5{w[W_W-1]}}, w}) + $signed({1'b0, rnd[MOV_W:32]});
		end
		if (nw > 21'sd32767) begin
			r = {1'b1, 16'h7FFF};
		end else if (nw < -21'sd32768) begin
			r = {1'b1, 16'h8000};
		end else begin
			r = {1'b0, nw[W_W-1:0]};
		end
		return r;
	endfunction

	// config registers
	logic [LRATE_W-1:0] lr_q;
	logic [RAD_W-1:0]   rad_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lr_q  <= LRATE_RESET;
			rad_q <= RAD_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_LEARNING_RATE:        lr_q  <= cfg_data;
				REG_NEIGHBOURHOOD_RADIUS: rad_q <= cfg_data[RAD_W-1:0];
				default: ;
			endcase
		end
	end

	// captured word
	logic [CMD_W-1:0] cmd_q;
	logic [W_W-1:0]   sx_q, sy_q;
	logic [RC_W-1:0]  row_q, col_q;

	always_ff @(posedge clk) begin
		if (cmd.cap_in) begin
			cmd_q <= s_tuser;
			sx_q  <= s_tdata[15:0];
			sy_q  <= s_tdata[31:16];
			row_q <= s_tdata[34:32];
			col_q <= s_tdata[37:35];
		end
	end

	logic          in_grid;
	logic [AW-1:0] in_addr;
	assign in_grid = (int'(row_q) < GRID_SIDE) && (int'(col_q) < GRID_SIDE);
	assign in_addr = AW'(int'(row_q) * GRID_SIDE + int'(col_q));

	// neuron counter
	logic [CW-1:0] cnt_row_q, cnt_col_q;
	logic [AW-1:0] cnt_addr;
	logic          cnt_last;
	assign cnt_addr = AW'(int'(cnt_row_q) * GRID_SIDE + int'(cnt_col_q));
	assign cnt_last = (cnt_row_q == LAST_RC) && (cnt_col_q == LAST_RC);

	always_ff @(posedge clk) begin
		if (cmd.srch_start || cmd.upd_start) begin
			cnt_row_q <= '0;
			cnt_col_q <= '0;
		end else if (cmd.srch_issue || cmd.upd_next) begin
			if (cnt_col_q == LAST_RC) begin
				cnt_col_q <= '0;
				cnt_row_q <= cnt_row_q + 1'b1;
			end else begin
				cnt_col_q <= cnt_col_q + 1'b1;
			end
		end
	end

	// weight store
	logic                   ram_we, ram_re;
	logic [AW-1:0]          ram_waddr, ram_raddr;
	logic [2*W_W-1:0]       ram_wdata, ram_rdata;
	logic [W_W:0]           nx, ny;

	assign ram_re    = cmd.read_issue || cmd.srch_issue || cmd.upd_read;
	assign ram_raddr = cmd.read_issue ? in_addr : cnt_addr;
	assign ram_we    = (cmd.load_wr && in_grid) || cmd.wb;
	assign ram_waddr = cmd.wb ? cnt_addr : in_addr;
	assign ram_wdata = cmd.wb ? {ny[W_W-1:0], nx[W_W-1:0]} : {sy_q, sx_q};

	ksom_ram #(.WIDTH(2 * W_W), .DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// winner search pipeline
	logic                v_s1, v_s2, v_s3, first_q;
	logic [CW-1:0]       row_s1, col_s1, row_s2, col_s2, row_s3, col_s3;
	logic signed [16:0]  dx_s2, dy_s2;
	logic signed [33:0]  sqx, sqy;
	logic [33:0]         sqx_s3, sqy_s3;
	logic [34:0]         d2, best_q;
	logic [CW-1:0]       win_row_q, win_col_q;

	assign sqx = dx_s2 * dx_s2;
	assign sqy = dy_s2 * dy_s2;
	assign d2  = {1'b0, sqx_s3} + {1'b0, sqy_s3};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= cmd.srch_issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		row_s1 <= cnt_row_q;
		col_s1 <= cnt_col_q;
		row_s2 <= row_s1;
		col_s2 <= col_s1;
		dx_s2  <= $signed({sx_q[W_W-1], sx_q}) - $signed({ram_rdata[15], ram_rdata[15:0]});
		dy_s2  <= $signed({sy_q[W_W-1], sy_q}) - $signed({ram_rdata[31], ram_rdata[31:16]});
		row_s3 <= row_s2;
		col_s3 <= col_s2;
		sqx_s3 <= sqx;
		sqy_s3 <= sqy;
		if (cmd.srch_start) begin
			first_q <= 1'b1;
		end else if (v_s3 && (first_q || d2 < best_q)) begin
			first_q   <= 1'b0;
			best_q    <= d2;
			win_row_q <= row_s3;
			win_col_q <= col_s3;
		end
	end

	// neighbourhood distance
	logic [CW-1:0]    dr, dc;
	logic [DSQ_W-1:0] dsq_q;
	logic [RR_W-1:0]  rr;
	assign dr = (cnt_row_q >= win_row_q) ? cnt_row_q - win_row_q : win_row_q - cnt_row_q;
	assign dc = (cnt_col_q >= win_col_q) ? cnt_col_q - win_col_q : win_col_q - cnt_col_q;
	assign rr = RR_W'(rad_q) * RR_W'(rad_q);

	logic [W_W-1:0] wx_q, wy_q;
	always_ff @(posedge clk) begin
		if (cmd.upd_read) begin
			dsq_q <= DSQ_W'(DSQ_W'(dr) * DSQ_W'(dr)) + DSQ_W'(DSQ_W'(dc) * DSQ_W'(dc));
		end
		if (cmd.upd_chk) begin
			wx_q <= ram_rdata[15:0];
			wy_q <= ram_rdata[31:16];
		end
	end

	// square root, two bits a cycle
	logic [SQV_W-1:0] sv_q, sres_q, sbit_q, ssum;
	logic             sqrt_busy_q;
	assign ssum = sres_q + sbit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sqrt_busy_q <= 1'b0;
		end else if (cmd.sqrt_start) begin
			sqrt_busy_q <= 1'b1;
		end else if (sqrt_busy_q && sbit_q[0]) begin
			sqrt_busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sqrt_start) begin
			sv_q   <= SQV_W'({dsq_q, 32'b0});
			sres_q <= '0;
			sbit_q <= SQV_W'(1) << SQ_TOP;
		end else if (sqrt_busy_q) begin
			if (sv_q >= ssum) begin
				sv_q   <= sv_q - ssum;
				sres_q <= (sres_q >> 1) + sbit_q;
			end else begin
				sres_q <= sres_q >> 1;
			end
			sbit_q <= sbit_q >> 2;
		end
	end

	// restoring divider, one quotient bit a cycle
	logic [RAD_W:0]    dv_rem_q, rem_sh;
	logic [DIV_W-1:0]  dv_quo_q;
	logic [RAD_W-1:0]  dv_den_q;
	logic [DCNT_W-1:0] dv_cnt_q;
	logic              div_busy_q, dv_ge;
	logic [PROD_W-1:0] prod_q;
	logic [K_W-1:0]    k_q;

	assign rem_sh = {dv_rem_q[RAD_W-1:0], dv_quo_q[DIV_W-1]};
	assign dv_ge  = rem_sh >= {1'b0, dv_den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_busy_q <= 1'b0;
		end else if (cmd.div_t_start || cmd.exp_div_start) begin
			div_busy_q <= 1'b1;
		end else if (div_busy_q && dv_cnt_q == '0) begin
			div_busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_t_start || cmd.exp_div_start) begin
			dv_rem_q <= '0;
			dv_cnt_q <= DCNT_W'(DIV_W - 1);
			if (cmd.div_t_start) begin
				dv_quo_q <= DIV_W'({sres_q[ROOT_W-1:0], 7'b0});
				dv_den_q <= rad_q;
			end else begin
				dv_quo_q <= prod_q[DIV_W+15:16];
				dv_den_q <= RAD_W'(k_q);
			end
		end else if (div_busy_q) begin
			dv_rem_q <= dv_ge ? rem_sh - {1'b0, dv_den_q} : rem_sh;
			dv_quo_q <= {dv_quo_q[DIV_W-2:0], dv_ge};
			dv_cnt_q <= dv_cnt_q - 1'b1;
		end
	end

	// exponential series, gain and update products
	logic [T_W-1:0]     t_q;
	logic [TERM_W-1:0]  term_q, sum_q;
	logic [TERM_W:0]    sum_rnd;
	logic [INFL_W-1:0]  rate_eff;
	logic [GAIN_W-1:0]  gain_q;
	logic signed [16:0] delx, dely;
	logic [MAG_W-1:0]   magx, magy;
	logic               negx_q, negy_q;
	logic [MOV_W-1:0]   prodx_q, prody_q;

	assign sum_rnd  = {1'b0, sum_q} + (TERM_W + 1)'(32768);
	assign rate_eff = (lr_q == LRATE_RESET) ? INFL_W'(65536) : INFL_W'(lr_q);
	assign delx     = $signed({sx_q[W_W-1], sx_q}) - $signed({wx_q[W_W-1], wx_q});
	assign dely     = $signed({sy_q[W_W-1], sy_q}) - $signed({wy_q[W_W-1], wy_q});
	assign magx     = delx[16] ? MAG_W'(-delx) : MAG_W'(delx);
	assign magy     = dely[16] ? MAG_W'(-dely) : MAG_W'(dely);

	always_ff @(posedge clk) begin
		if (cmd.upd_chk) begin
			term_q <= TERM_W'(1) << 32;
			sum_q  <= TERM_W'(1) << 32;
			k_q    <= K_W'(1);
		end else if (cmd.exp_acc) begin
			term_q <= TERM_W'(dv_quo_q);
			if (k_q[0]) begin
				sum_q <= sum_q - TERM_W'(dv_quo_q);
			end else begin
				sum_q <= sum_q + TERM_W'(dv_quo_q);
			end
			k_q <= k_q + 1'b1;
		end
		if (cmd.t_latch) begin
			t_q <= (dv_quo_q > DIV_W'(T_MAX)) ? T_MAX : T_W'(dv_quo_q);
		end
		if (cmd.exp_mul) begin
			prod_q <= PROD_W'(term_q) * PROD_W'(t_q);
		end
		if (cmd.gain_calc) begin
			gain_q <= GAIN_W'(rate_eff) * GAIN_W'(sum_rnd[TERM_W-1:16]);
		end
		if (cmd.move_mul) begin
			negx_q  <= delx[16];
			negy_q  <= dely[16];
			prodx_q <= MOV_W'(magx) * MOV_W'(gain_q);
			prody_q <= MOV_W'(magy) * MOV_W'(gain_q);
		end
	end

	// write back
	logic [W_W-1:0] res_x_q, res_y_q;
	logic           sat_q;
	assign nx = step_w(wx_q, negx_q, prodx_q);
	assign ny = step_w(wy_q, negy_q, prody_q);

	always_ff @(posedge clk) begin
		if (cmd.srch_start) begin
			sat_q <= 1'b0;
		end else if (cmd.wb) begin
			sat_q <= sat_q | nx[W_W] | ny[W_W];
			if (cnt_row_q == win_row_q && cnt_col_q == win_col_q) begin
				res_x_q <= nx[W_W-1:0];
				res_y_q <= ny[W_W-1:0];
			end
		end
	end

	// output register
	logic                  out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q, out_next;

	always_comb begin
		out_next = '0;
		case (cmd_q)
			CMD_TRAIN: out_next = {1'b0, sat_q, res_y_q, res_x_q,
					RC_W'(win_col_q), RC_W'(win_row_q)};
			CMD_READ:  out_next = {2'b0, in_grid ? ram_rdata : 32'b0, col_q, row_q};
			CMD_LOAD:  out_next = {2'b0, in_grid ? {sy_q, sx_q} : 32'b0, col_q, row_q};
			default:   out_next = {34'b0, col_q, row_q};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_data_q <= out_next;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	assign stat.cmd       = cmd_q;
	assign stat.cnt_last  = cnt_last;
	assign stat.srch_busy = v_s1 || v_s2 || v_s3;
	assign stat.in_nbhd   = {dsq_q, 16'b0} <= NB_W'(rr);
	assign stat.t_zero    = (dsq_q == '0) || (rad_q == '0);
	assign stat.sqrt_busy = sqrt_busy_q;
	assign stat.div_busy  = div_busy_q;
	assign stat.exp_done  = (dv_quo_q == '0) || (k_q == K_LAST);
	assign stat.out_free  = !out_valid_q || m_tready;
endmodule

/* src/ksom_ctrl.sv */
// ----------------------------------------------------------------------------
// ksom_ctrl
// controller: sequences load, read and the two passes of a training step
// ----------------------------------------------------------------------------
module ksom_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  ksom_pkg::ksom_stat_t stat,
	output ksom_pkg::ksom_cmd_t  cmd
);
	import ksom_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.cap_in = 1'b1;
					state_d    = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				case (stat.cmd)
					CMD_TRAIN: begin
						cmd.srch_start = 1'b1;
						state_d        = ST_SRCH;
					end
					CMD_READ: begin
						cmd.read_issue = 1'b1;
						state_d        = ST_READ_WAIT;
					end
					CMD_LOAD: begin
						cmd.load_wr = 1'b1;
						state_d     = ST_OUT;
					end
					default: state_d = ST_OUT;
				endcase
			end
			ST_READ_WAIT: state_d = ST_OUT;
			ST_SRCH: begin
				cmd.srch_issue = 1'b1;
				if (stat.cnt_last) begin
					state_d = ST_SRCH_WAIT;
				end
			end
			ST_SRCH_WAIT: begin
				if (!stat.srch_busy) begin
					cmd.upd_start = 1'b1;
					state_d       = ST_UPD_RD;
				end
			end
			ST_UPD_RD: begin
				cmd.upd_read = 1'b1;
				state_d      = ST_UPD_CHK;
			end
			ST_UPD_CHK: begin
				cmd.upd_chk = 1'b1;
				if (!stat.in_nbhd) begin
					if (stat.cnt_last) begin
						state_d = ST_OUT;
					end else begin
						cmd.upd_next = 1'b1;
						state_d      = ST_UPD_RD;
					end
				end else if (stat.t_zero) begin
					state_d = ST_GAIN;
				end else begin
					cmd.sqrt_start = 1'b1;
					state_d        = ST_SQRT;
				end
			end
			ST_SQRT: begin
				if (!stat.sqrt_busy) begin
					cmd.div_t_start = 1'b1;
					state_d         = ST_DIV_T;
				end
			end
			ST_DIV_T: begin
				if (!stat.div_busy) begin
					state_d = ST_T_LATCH;
				end
			end
			ST_T_LATCH: begin
				cmd.t_latch = 1'b1;
				state_d     = ST_EXP_MUL;
			end
			ST_EXP_MUL: begin
				cmd.exp_mul = 1'b1;
				state_d     = ST_EXP_DSTART;
			end
			ST_EXP_DSTART: begin
				cmd.exp_div_start = 1'b1;
				state_d           = ST_EXP_DIV;
			end
			ST_EXP_DIV: begin
				if (!stat.div_busy) begin
					state_d = ST_EXP_ACC;
				end
			end
			ST_EXP_ACC: begin
				cmd.exp_acc = 1'b1;
				state_d     = stat.exp_done ? ST_GAIN : ST_EXP_MUL;
			end
			ST_GAIN: begin
				cmd.gain_calc = 1'b1;
				state_d       = ST_MOVE;
			end
			ST_MOVE: begin
				cmd.move_mul = 1'b1;
				state_d      = ST_WB;
			end
			ST_WB: begin
				cmd.wb = 1'b1;
				if (stat.cnt_last) begin
					state_d = ST_OUT;
				end else begin
					cmd.upd_next = 1'b1;
					state_d      = ST_UPD_RD;
				end
			end
			ST_OUT: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule

/* src/kohonen_som_training_step_unit.sv */
// ----------------------------------------------------------------------------
// kohonen_som_training_step_unit
// self-organizing map on a square grid of two-component Q4.12 weights
// ----------------------------------------------------------------------------
// s_tuser carries the command (train, read, load), s_tdata the sample or load
// value and the addressed neuron. every input word gives one output word on
// m_tdata. the cfg channel writes learning rate and radius, always ready.
// load writes the weight store first; read waits for the registered ram read.
// train first runs the winner search (N = GRID_SIDE^2, one neuron read per
// cycle through a 4-stage pipeline), then visits every neuron again: one
// outside the radius is only read and checked, the winner goes straight to
// gain, move and write back, and every other neuron inside the radius takes
// 22 square root steps, then a 32-bit divide for the distance ratio and one
// 32-bit divide per series term (up to 10, stopping when a term is zero),
// all on the one bit-serial divider; then the output register is loaded.
// the next word is taken once the result sits in the output register; if the
// receiver stalls, the unit waits with the following result until it drains.
// reset clears control and sets rate and radius; weights are undefined until
// loaded.
// ----------------------------------------------------------------------------
module kohonen_som_training_step_unit #(
	parameter int GRID_SIDE = ksom_pkg::GRID_SIDE_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// command
	input  logic [ksom_pkg::CMD_W-1:0]      s_tuser,
	// sample_x, sample_y, neuron_row, neuron_col, 2 pad bits
	input  logic [ksom_pkg::IN_DATA_W-1:0]  s_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// winner_row, winner_col, weight_x, weight_y, saturated, 1 pad bit
	output logic [ksom_pkg::OUT_DATA_W-1:0] m_tdata,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [ksom_pkg::IDX_W-1:0]      cfg_index,
	input  logic [ksom_pkg::LRATE_W-1:0]    cfg_data
);
	import ksom_pkg::*;

	ksom_cmd_t  cmd;
	ksom_stat_t stat;

	assign cfg_ready = 1'b1;

	ksom_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	ksom_dp #(.GRID_SIDE(GRID_SIDE)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !stat.srch_busy && !stat.sqrt_busy && !stat.div_busy)
		else $error("iterative unit busy while idle");

	a_one_unit: assert property (@(posedge clk) disable iff (!arst_n)
		!(stat.sqrt_busy && stat.div_busy))
		else $error("square root and divider running together");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("word taken while previous word in progress");
endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// randomized regression of the self-organizing map training unit
// ----------------------------------------------------------------------------
// loads every neuron, then runs directed words and randomized phases of
// train, read, load and unused commands under several rate and radius
// settings. a scoreboard keeps its own copy of the grid and predicts each
// output word; both stream sides idle at random and the receiver once holds
// off long enough to stall the input.
// ----------------------------------------------------------------------------
module tb_top;
	import ksom_pkg::*;

	localparam int LIMIT = 30000000;

	localparam logic [CMD_W-1:0] CMD_SPARE    = 2'd3;
	localparam logic [IDX_W-1:0] REG_SPARE_LO = 2'd2;
	localparam logic [IDX_W-1:0] REG_SPARE_HI = 2'd3;

	typedef struct {
		logic [RC_W-1:0] row;
		logic [RC_W-1:0] col;
		logic [W_W-1:0]  wx;
		logic [W_W-1:0]  wy;
		logic            sat;
	} som_word_t;

	class som_tracker;
		logic [31:0] wts [64];
		int unsigned rate;
		int unsigned radius;
		som_word_t   pending_results [$];
		int          errors;

		function new();
			rate = LRATE_RESET;
			radius = RAD_RESET;
			errors = 0;
			foreach (wts[i]) wts[i] = '0;
		endfunction

		function void write_reg(logic [IDX_W-1:0] idx, logic [LRATE_W-1:0] val);
			if (idx == REG_LEARNING_RATE) rate = val;
			else if (idx == REG_NEIGHBOURHOOD_RADIUS) radius = val[RAD_W-1:0];
		endfunction

		function longint unsigned int_sqrt(longint unsigned v);
			longint unsigned res;
			longint unsigned b;
			res = 0;
			b = 64'h1 << 62;
			while (b > v) b >>= 2;
			while (b != 0) begin
				if (v >= res + b) begin
					v -= res + b;
					res = (res >> 1) + b;
				end else
					res >>= 1;
				b >>= 2;
			end
			return res;
		endfunction

		function longint unsigned decay(longint unsigned t);
			longint unsigned term;
			longint unsigned sum;
			term = 64'h1 << 32;
			sum = term;
			for (int k = 1; k <= 10; k++) begin
				term = (term * t) / (65536 * k);
				if (k % 2) sum -= term;
				else sum += term;
			end
			return (sum + 32768) >> 16;
		endfunction

		function logic [W_W-1:0] pull(logic [W_W-1:0] w, logic [W_W-1:0] x,
				longint unsigned gain, inout logic sat);
			longint delta;
			longint unsigned mag;
			longint unsigned q;
			longint nw;
			delta = longint'($signed(x)) - longint'($signed(w));
			mag = delta < 0 ? -delta : delta;
			q = (mag * gain + (64'h1 << 31)) >> 32;
			nw = delta < 0 ? longint'($signed(w)) - longint'(q) : longint'($signed(w)) + longint'(q);
			if (nw > 32767) begin nw = 32767; sat = 1; end
			if (nw < -32768) begin nw = -32768; sat = 1; end
			return nw[W_W-1:0];
		endfunction

		function void note_word(logic [CMD_W-1:0] cmd, logic [W_W-1:0] sx, logic [W_W-1:0] sy,
				logic [RC_W-1:0] row, logic [RC_W-1:0] col);
			som_word_t r;
			int win;
			longint unsigned best;
			longint unsigned d2;
			longint dx;
			longint dy;
			longint unsigned rr;
			longint unsigned dsq;
			longint unsigned t;
			longint unsigned gain;
			longint unsigned eff;
			int dr;
			int dc;
			logic sat;
			r.row = row;
			r.col = col;
			r.wx = '0;
			r.wy = '0;
			r.sat = 0;
			if (cmd == CMD_TRAIN) begin
				win = 0;
				best = 0;
				sat = 0;
				for (int i = 0; i < 64; i++) begin
					dx = longint'($signed(sx)) - longint'($signed(wts[i][15:0]));
					dy = longint'($signed(sy)) - longint'($signed(wts[i][31:16]));
					d2 = dx * dx + dy * dy;
					if (i == 0 || d2 < best) begin
						best = d2;
						win = i;
					end
				end
				eff = rate == 65535 ? 65536 : rate;
				rr = longint'(radius) * radius;
				for (int i = 0; i < 64; i++) begin
					dr = i / 8 - win / 8;
					dc = i % 8 - win % 8;
					dsq = dr * dr + dc * dc;
					if (dsq * 65536 > rr) continue;
					t = 0;
					if (dsq != 0 && radius != 0) begin
						t = int_sqrt(dsq << 32) * 128 / radius;
						if (t > 32768) t = 32768;
					end
					gain = eff * decay(t);
					wts[i][15:0] = pull(wts[i][15:0], sx, gain, sat);
					wts[i][31:16] = pull(wts[i][31:16], sy, gain, sat);
				end
				r.row = RC_W'(win / 8);
				r.col = RC_W'(win % 8);
				r.wx = wts[win][15:0];
				r.wy = wts[win][31:16];
				r.sat = sat;
			end else if (cmd == CMD_READ) begin
				r.wx = wts[row * 8 + col][15:0];
				r.wy = wts[row * 8 + col][31:16];
			end else if (cmd == CMD_LOAD) begin
				wts[row * 8 + col] = {sy, sx};
				r.wx = sx;
				r.wy = sy;
			end
			pending_results.push_back(r);
		endfunction

		function void check_word(logic [OUT_DATA_W-1:0] d);
			som_word_t e;
			if (pending_results.size() == 0) begin
				$error("output word with nothing pending: %h", d);
				errors++;
				return;
			end
			e = pending_results.pop_front();
			if (d[2:0] !== e.row) begin
				$error("winner_row exp %0d got %0d", e.row, d[2:0]); errors++;
			end
			if (d[5:3] !== e.col) begin
				$error("winner_col exp %0d got %0d", e.col, d[5:3]); errors++;
			end
			if (d[21:6] !== e.wx) begin
				$error("weight_x exp %h got %h", e.wx, d[21:6]); errors++;
			end
			if (d[37:22] !== e.wy) begin
				$error("weight_y exp %h got %h", e.wy, d[37:22]); errors++;
			end
			if (d[38] !== e.sat) begin
				$error("saturated exp %0d got %0d", e.sat, d[38]); errors++;
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [CMD_W-1:0]      s_tuser;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [IDX_W-1:0]      cfg_index;
	logic [LRATE_W-1:0]    cfg_data;

	som_tracker tracker;
	int         cycles;
	int         stall_pct;
	int         hold_len;
	int         hold_left;
	int         burst_left;
	int         train_pct;

	kohonen_som_training_step_unit DUT (.*);

	always begin
		clk = 1'b1; #10;
		clk = 1'b0; #10;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// receiver stall pattern with an occasional long hold-off
	always @(posedge clk) begin
		if (hold_len > 0 && hold_left == 0) begin
			hold_left = hold_len;
			hold_len = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else
			m_tready <= ($urandom_range(0, 99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (m_tvalid && m_tready) tracker.check_word(m_tdata);
		if (s_tvalid && s_tready)
			tracker.note_word(s_tuser, s_tdata[15:0], s_tdata[31:16],
				s_tdata[34:32], s_tdata[37:35]);
		if (cfg_valid && cfg_ready) tracker.write_reg(cfg_index, cfg_data);
	end

	task automatic send_word(logic [CMD_W-1:0] cmd, logic [W_W-1:0] x, logic [W_W-1:0] y,
			logic [RC_W-1:0] row, logic [RC_W-1:0] col);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {2'b00, col, row, y, x};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (tracker.pending_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_cfg(logic [IDX_W-1:0] idx, logic [LRATE_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_word();
		int pick;
		int n;
		logic [15:0] x;
		logic [15:0] y;
		pick = $urandom_range(0, 99);
		x = 16'($urandom);
		y = 16'($urandom);
		if (pick < train_pct) begin
			if ($urandom_range(0, 1)) begin
				n = $urandom_range(0, 63);
				x = 16'(tracker.wts[n][15:0] + $urandom_range(0, 511) - 256);
				y = 16'(tracker.wts[n][31:16] + $urandom_range(0, 511) - 256);
			end
			send_word(CMD_TRAIN, x, y, RC_W'($urandom), RC_W'($urandom));
		end else if (pick < train_pct + 35)
			send_word(CMD_READ, x, y, RC_W'($urandom), RC_W'($urandom));
		else if (pick < 95)
			send_word(CMD_LOAD, x, y, RC_W'($urandom), RC_W'($urandom));
		else
			send_word(CMD_SPARE, x, y, RC_W'($urandom), RC_W'($urandom));
	endtask

	task automatic run_phase(logic [15:0] rate, logic [15:0] rad, int words, int tpct, int spct);
		drain();
		write_cfg(REG_LEARNING_RATE, rate);
		write_cfg(REG_NEIGHBOURHOOD_RADIUS, rad);
		train_pct = tpct;
		stall_pct = spct;
		repeat (words) random_word();
	endtask

	initial begin
		tracker = new();
		cycles = 0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tuser = '0;
		s_tdata = '0;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		stall_pct = 0;
		hold_len = 0;
		hold_left = 0;
		burst_left = 0;
		train_pct = 30;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill the grid, the first and last corners at the extremes, a tie at the front
		for (int i = 0; i < 64; i++) begin
			if (i < 2)
				send_word(CMD_LOAD, 16'h7FFF, 16'h7FFF, RC_W'(i / 8), RC_W'(i % 8));
			else if (i == 63)
				send_word(CMD_LOAD, 16'h8000, 16'h8000, 3'd7, 3'd7);
			else
				send_word(CMD_LOAD, 16'($urandom), 16'($urandom), RC_W'(i / 8),
					RC_W'(i % 8));
		end
		send_word(CMD_READ, 16'hFFFF, 16'h0000, 3'd0, 3'd0);
		send_word(CMD_READ, 16'h0000, 16'hFFFF, 3'd7, 3'd7);
		send_word(CMD_SPARE, 16'h1234, 16'h8765, 3'd7, 3'd5);
		send_word(CMD_TRAIN, 16'h7FFF, 16'h7FFF, 3'd0, 3'd0);
		send_word(CMD_TRAIN, 16'h8000, 16'h8000, 3'd3, 3'd3);
		drain();
		write_cfg(REG_SPARE_LO, 16'hFFFF);
		write_cfg(REG_SPARE_HI, 16'h0000);
		write_cfg(REG_NEIGHBOURHOOD_RADIUS, 16'd0);
		send_word(CMD_TRAIN, 16'h8000, 16'h7FFF, 3'd0, 3'd0);
		send_word(CMD_TRAIN, 16'h0000, 16'h0000, 3'd0, 3'd0);
		drain();
		write_cfg(REG_LEARNING_RATE, 16'd0);
		send_word(CMD_TRAIN, 16'h4000, 16'hC000, 3'd0, 3'd0);
		send_word(CMD_READ, 16'h0000, 16'h0000, 3'd4, 3'd2);

		run_phase(16'hFFFF, 16'd0, 200, 30, 0);
		run_phase(16'd1000, 16'd256, 250, 30, 30);
		drain();
		hold_len = 600;
		run_phase(16'd40000, 16'd362, 250, 20, 10);
		run_phase(16'd0, 16'd128, 200, 30, 60);
		run_phase(16'd12345, 16'd8191, 60, 5, 20);
		run_phase(16'($urandom), 16'($urandom_range(0, 512)), 300, 30, 40);
		run_phase(16'd65534, 16'd256, 290, 30, 0);

		drain();
		repeat (50) @(posedge clk);
		if (tracker.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
